/* hdl/mm128_pkg.sv */
// Package: shared types and constants for the 128-bit Montgomery multiplier.
package mm128_pkg;

    localparam logic [2:0] OP_MONT  = 3'd0;
    localparam logic [2:0] OP_ENTER = 3'd1;
    localparam logic [2:0] OP_EXIT  = 3'd2;
    localparam logic [2:0] OP_FULL  = 3'd3;
    localparam logic [2:0] OP_ACC   = 3'd4;

    localparam logic [1:0] REG_MOD_LOW  = 2'd0;
    localparam logic [1:0] REG_MOD_HIGH = 2'd1;
    localparam logic [1:0] REG_RSQ_LOW  = 2'd2;
    localparam logic [1:0] REG_RSQ_HIGH = 2'd3;

    // operand select for the datapath A/B registers
    localparam logic [2:0] SEL_IN_A    = 3'd0;
    localparam logic [2:0] SEL_IN_B    = 3'd1;
    localparam logic [2:0] SEL_RSQ     = 3'd2;
    localparam logic [2:0] SEL_ONE     = 3'd3;
    localparam logic [2:0] SEL_RESULT  = 3'd4;
    localparam logic [2:0] SEL_SAVE    = 3'd5;
    localparam logic [2:0] SEL_RUNNING = 3'd6;
    localparam logic [2:0] SEL_HELD_B  = 3'd7;

    typedef struct packed {
        logic       load_a;
        logic [2:0] sel_a;
        logic       load_b;
        logic [2:0] sel_b;
        logic       hold_b;     // capture request b at acceptance
        logic       start;      // begin one Montgomery product on A, B
        logic       save;       // copy product result into save register
        logic       run_load_a; // running := input a
        logic       run_load_p; // running := product result
        logic       out_load;   // output := product result
        logic       out_run;    // output := input a (chain start)
        logic       out_zero;   // output := zero
    } mm128_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mm128_sts_t;

endpackage

/* hdl/mm128_if.sv */
// Interfaces: request and result channels.
interface mm128_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [63:0] a_low;
    logic [63:0] a_high;
    logic [63:0] b_low;
    logic [63:0] b_high;
    logic        chain_start;
    modport source (output valid, operation, a_low, a_high, b_low, b_high, chain_start,
                    input ready);
    modport sink (input valid, operation, a_low, a_high, b_low, b_high, chain_start,
                  output ready);
endinterface

interface mm128_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] result_low;
    logic [63:0] result_high;
    modport source (output valid, result_low, result_high, input ready);
    modport sink (input valid, result_low, result_high, output ready);
endinterface

/* hdl/mm128_datapath.sv */
// Datapath: operand registers, 64x64 multiply-accumulate on a 32x32 multiplier, reduction.
module mm128_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  mm128_pkg::mm128_cmd_t cmd,
    output mm128_pkg::mm128_sts_t sts,
    input  logic [63:0]         in_a_low,
    input  logic [63:0]         in_a_high,
    input  logic [63:0]         in_b_low,
    input  logic [63:0]         in_b_high,
    input  logic [63:0]         mod_low,
    input  logic [63:0]         mod_high,
    input  logic [63:0]         rsq_low,
    input  logic [63:0]         rsq_high,
    output logic [127:0]        result
);
    // product step sequence
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_M0   = 4'd1;
    localparam logic [3:0] ST_M1   = 4'd2;
    localparam logic [3:0] ST_M2   = 4'd3;
    localparam logic [3:0] ST_M3   = 4'd4;
    localparam logic [3:0] ST_R0   = 4'd5;
    localparam logic [3:0] ST_R1   = 4'd6;
    localparam logic [3:0] ST_R2   = 4'd7;
    localparam logic [3:0] ST_R3   = 4'd8;
    localparam logic [3:0] ST_SUM  = 4'd9;
    localparam logic [3:0] ST_SUB  = 4'd10;

    logic [3:0]   step_reg, step_next;
    logic [1:0]   sub_reg, sub_next;
    logic [127:0] a_reg, b_reg, save_reg, run_reg, res_reg, held_b_reg;
    logic [63:0]  t0_reg, t1_reg, t2_reg, t3_reg, m1h_reg, c_reg, xl_reg, xh_reg;
    logic [63:0]  k_reg;
    logic [128:0] s_reg;
    logic [63:0]  mac_x, mac_y, mac_c, mac_d;
    logic [127:0] mac_out, acc_reg, acc_base, acc_add;
    logic [31:0]  mul_x, mul_y;
    logic [63:0]  mul_p;
    logic         mac_step, mac_last;
    logic [129:0] diff;
    logic [127:0] op_a, op_b;

    // each multiply-accumulate step forms its partial products in turn on the 32x32 multiplier
    assign mac_step = (step_reg >= ST_M0) && (step_reg <= ST_R3);
    assign mac_last = mac_step && (sub_reg == 2'd3);

    // partial products in order lo*lo, lo*hi, hi*lo, hi*hi
    assign mul_x = sub_reg[1] ? mac_x[63:32] : mac_x[31:0];
    assign mul_y = sub_reg[0] ? mac_y[63:32] : mac_y[31:0];
    assign mul_p = {32'd0, mul_x} * {32'd0, mul_y};

    always_comb
    begin
        unique case (sub_reg)
            2'd0:       acc_add = {64'd0, mul_p};
            2'd1, 2'd2: acc_add = {32'd0, mul_p, 32'd0};
            default:    acc_add = {mul_p, 64'd0};
        endcase
    end

    // addends enter with the first partial product; total always fits 128 bits
    assign acc_base = (sub_reg == 2'd0) ? ({64'd0, mac_c} + {64'd0, mac_d}) : acc_reg;
    assign mac_out  = acc_base + acc_add;
    assign sub_next = mac_step ? sub_reg + 2'd1 : 2'd0;

    always_comb
    begin
        mac_x = 64'd0;
        mac_y = 64'd0;
        mac_c = 64'd0;
        mac_d = 64'd0;
        unique case (step_reg)
            ST_M0:
            begin
                mac_x = a_reg[63:0];   mac_y = b_reg[63:0];
            end
            ST_M1:
            begin
                mac_x = a_reg[63:0];   mac_y = b_reg[127:64]; mac_c = t1_reg;
            end
            ST_M2:
            begin
                mac_x = a_reg[127:64]; mac_y = b_reg[63:0];   mac_c = t1_reg;
            end
            ST_M3:
            begin
                mac_x = a_reg[127:64]; mac_y = b_reg[127:64];
                mac_c = m1h_reg;       mac_d = c_reg;
            end
            ST_R0:
            begin
                mac_x = k_reg; mac_y = mod_low;  mac_c = t0_reg;
            end
            ST_R1:
            begin
                mac_x = k_reg; mac_y = mod_high; mac_c = t1_reg; mac_d = c_reg;
            end
            ST_R2:
            begin
                mac_x = k_reg; mac_y = mod_low;  mac_c = xl_reg;
            end
            ST_R3:
            begin
                mac_x = k_reg; mac_y = mod_high; mac_c = xh_reg; mac_d = c_reg;
            end
            default:
            begin
                mac_x = 64'd0;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        unique case (step_reg)
            ST_IDLE: step_next = cmd.start ? ST_M0 : ST_IDLE;
            ST_M0:   step_next = ST_M1;
            ST_M1:   step_next = ST_M2;
            ST_M2:   step_next = ST_M3;
            ST_M3:   step_next = ST_R0;
            ST_R0:   step_next = ST_R1;
            ST_R1:   step_next = ST_R2;
            ST_R2:   step_next = ST_R3;
            ST_R3:   step_next = ST_SUM;
            ST_SUM:  step_next = ST_SUB;
            ST_SUB:  step_next = ST_IDLE;
            default: step_next = ST_IDLE;
        endcase
        if (mac_step && !mac_last)
        begin
            step_next = step_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= ST_IDLE;
            sub_reg  <= 2'd0;
        end
        else
        begin
            step_reg <= step_next;
            sub_reg  <= sub_next;
        end
    end

    function automatic logic [127:0] pick(input logic [2:0] sel, input logic [127:0] ina,
                                          input logic [127:0] inb, input logic [127:0] rsq,
                                          input logic [127:0] res, input logic [127:0] sv,
                                          input logic [127:0] run, input logic [127:0] held);
        logic [127:0] v;
        v = 128'd0;
        unique case (sel)
            mm128_pkg::SEL_IN_A:    v = ina;
            mm128_pkg::SEL_IN_B:    v = inb;
            mm128_pkg::SEL_RSQ:     v = rsq;
            mm128_pkg::SEL_ONE:     v = 128'd1;
            mm128_pkg::SEL_RESULT:  v = res;
            mm128_pkg::SEL_SAVE:    v = sv;
            mm128_pkg::SEL_RUNNING: v = run;
            mm128_pkg::SEL_HELD_B:  v = held;
            default:                v = 128'd0;
        endcase
        return v;
    endfunction

    assign op_a = pick(cmd.sel_a, {in_a_high, in_a_low}, {in_b_high, in_b_low},
                       {rsq_high, rsq_low}, res_reg, save_reg, run_reg, held_b_reg);
    assign op_b = pick(cmd.sel_b, {in_a_high, in_a_low}, {in_b_high, in_b_low},
                       {rsq_high, rsq_low}, res_reg, save_reg, run_reg, held_b_reg);

    assign diff = {1'b0, s_reg} - {2'b00, mod_high, mod_low};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 128'd0;
        end
        else if (cmd.run_load_a)
        begin
            run_reg <= {in_a_high, in_a_low};
        end
        else if (cmd.run_load_p)
        begin
            run_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_step)
        begin
            acc_reg <= mac_out;
        end
        if (cmd.hold_b)
        begin
            held_b_reg <= {in_b_high, in_b_low};
        end
        if (cmd.load_a)
        begin
            a_reg <= op_a;
        end
        if (cmd.load_b)
        begin
            b_reg <= op_b;
        end
        if (cmd.save)
        begin
            save_reg <= res_reg;
        end
        // multiply-accumulate results land with the last partial product
        if (!mac_step || mac_last)
        begin
            unique case (step_reg)
                ST_M0:
                begin
                    t0_reg <= mac_out[63:0];  t1_reg <= mac_out[127:64];
                    k_reg  <= 64'd0 - mac_out[63:0];
                end
                ST_M1:
                begin
                    t1_reg <= mac_out[63:0];  m1h_reg <= mac_out[127:64];
                end
                ST_M2:
                begin
                    t1_reg <= mac_out[63:0];  c_reg <= mac_out[127:64];
                end
                ST_M3:
                begin
                    t2_reg <= mac_out[63:0];  t3_reg <= mac_out[127:64];
                end
                ST_R0:
                begin
                    c_reg <= mac_out[127:64];
                end
                ST_R1:
                begin
                    xl_reg <= mac_out[63:0];  xh_reg <= mac_out[127:64];
                    k_reg  <= 64'd0 - mac_out[63:0];
                end
                ST_R2:
                begin
                    c_reg <= mac_out[127:64];
                end
                ST_R3:
                begin
                    xl_reg <= mac_out[63:0];  xh_reg <= mac_out[127:64];
                end
                ST_SUM:
                begin
                    s_reg <= {1'b0, t3_reg, t2_reg} + {1'b0, xh_reg, xl_reg};
                end
                ST_SUB:
                begin
                    res_reg <= diff[129] ? s_reg[127:0] : diff[127:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign sts.busy = (step_reg != ST_IDLE);
    assign sts.done = (step_reg == ST_SUB);
    assign result   = res_reg;

`ifndef SYNTH
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |-> step_reg == ST_IDLE) else $error("product started while busy");
    a_done_next: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg == ST_SUB |=> step_reg == ST_IDLE) else $error("sequence overrun");
    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> step_reg == ST_M0) else $error("start not taken");
    a_sub_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !mac_step |-> sub_reg == 2'd0) else $error("partial product count out of step");
`endif
endmodule

/* hdl/mm128_ctrl.sv */
// Controller: sequences products per operation and runs the handshakes.
module mm128_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            operation,
    input  logic                  chain_start,
    output logic                  out_valid,
    input  logic                  out_ready,
    output mm128_pkg::mm128_cmd_t cmd,
    input  mm128_pkg::mm128_sts_t sts
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_P1    = 3'd1; // waiting on first product
    localparam logic [2:0] S_P2    = 3'd2; // full: b to form
    localparam logic [2:0] S_P3    = 3'd3; // full: waiting on later products
    localparam logic [2:0] S_P4    = 3'd4; // full: start multiply or exit
    localparam logic [2:0] S_OUT   = 3'd5;

    // full product phases, kept in op_reg after the first product
    localparam logic [2:0] PH_FORM_B = 3'd7;
    localparam logic [2:0] PH_MULT   = 3'd6;
    localparam logic [2:0] PH_MULTED = 3'd5;
    localparam logic [2:0] PH_EXIT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic       out_valid_reg, out_valid_next;
    logic       take;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign take      = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    op_next    = operation;
                    cmd.load_a = 1'b1;
                    cmd.sel_a  = mm128_pkg::SEL_IN_A;
                    cmd.load_b = 1'b1;
                    cmd.hold_b = 1'b1;
                    unique case (operation)
                        mm128_pkg::OP_MONT:
                        begin
                            cmd.sel_b = mm128_pkg::SEL_IN_B; cmd.start = 1'b1;
                            state_next = S_P1;
                        end
                        mm128_pkg::OP_ENTER, mm128_pkg::OP_FULL:
                        begin
                            cmd.sel_b = mm128_pkg::SEL_RSQ; cmd.start = 1'b1;
                            state_next = S_P1;
                        end
                        mm128_pkg::OP_EXIT:
                        begin
                            cmd.sel_b = mm128_pkg::SEL_ONE; cmd.start = 1'b1;
                            state_next = S_P1;
                        end
                        mm128_pkg::OP_ACC:
                        begin
                            if (chain_start)
                            begin
                                cmd.run_load_a = 1'b1;
                                cmd.out_run    = 1'b1;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                cmd.sel_a = mm128_pkg::SEL_RUNNING;
                                cmd.sel_b = mm128_pkg::SEL_IN_A;
                                cmd.start = 1'b1;
                                state_next = S_P1;
                            end
                        end
                        default:
                        begin
                            cmd.out_zero   = 1'b1;
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_P1:
            begin
                if (sts.done)
                begin
                    state_next = S_OUT;
                    if (op_reg == mm128_pkg::OP_FULL)
                    begin
                        state_next = S_P2;
                    end
                end
            end
            S_P2:
            begin
                // x saved; form y = b in Montgomery form
                cmd.save   = 1'b1;
                cmd.load_a = 1'b1; cmd.sel_a = mm128_pkg::SEL_HELD_B;
                cmd.load_b = 1'b1; cmd.sel_b = mm128_pkg::SEL_RSQ;
                cmd.start  = 1'b1;
                state_next = S_P3;
                op_next    = PH_FORM_B;
            end
            S_P3:
            begin
                if (sts.done)
                begin
                    // after product y, multiply; after multiply, exit; after exit, output
                    state_next = (op_reg == PH_FORM_B) ? S_P4 : S_OUT;
                    op_next    = (op_reg == PH_FORM_B) ? PH_MULT : op_reg;
                end
            end
            S_P4:
            begin
                cmd.load_a = 1'b1;
                cmd.load_b = 1'b1;
                cmd.start  = 1'b1;
                state_next = S_P3;
                if (op_reg == PH_MULT)
                begin
                    cmd.sel_a = mm128_pkg::SEL_SAVE;
                    cmd.sel_b = mm128_pkg::SEL_RESULT;
                    op_next   = PH_MULTED;
                end
                else
                begin
                    cmd.sel_a = mm128_pkg::SEL_RESULT;
                    cmd.sel_b = mm128_pkg::SEL_ONE;
                    op_next   = mm128_pkg::OP_FULL;
                end
            end
            S_OUT:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
                if (op_reg == mm128_pkg::OP_ACC)
                begin
                    cmd.run_load_p = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // full product sequencing within S_P3
        if (state_reg == S_P3 && sts.done && op_reg == PH_MULTED)
        begin
            state_next = S_P4;
            op_next    = PH_EXIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= mm128_pkg::OP_MONT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.busy |-> !in_ready) else $error("request taken during product");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg) else $error("result dropped");
    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.out_load && cmd.out_zero)) else $error("output double load");
`endif
endmodule

/* hdl/montgomery_mul_128_core.sv */
// Top level: 128-bit Montgomery multiplier with configuration registers.
//
// Requests enter on req (valid/ready); one result leaves on res per request.
// Config: cfg_we/cfg_index/cfg_data write modulus (0,1) and R^2 mod Q (2,3);
// the user must write them only while idle; the block does not enforce this.
// Each Montgomery product runs eight 64x64 multiply-accumulate steps of four
// partial products each on one shared 32x32 multiplier, then sum and
// conditional subtract.
// Ops 0, 1, 2 and non-start accumulate run one product, the full modular
// product runs four, and chain start and unused codes run none.
// One request at a time: req.ready is low from acceptance until the result
// has been taken, so no new request is taken while one is in flight.
// A stalled receiver holds the result in the output register and blocks
// new requests.
// Reset clears the running product, sets modulus to one and R^2 to zero.
module montgomery_mul_128_core (
    input  logic         clk,
    input  logic         rst_n,
    mm128_req_if.sink    req,
    mm128_res_if.source  res,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);
    logic [63:0]  mod_low_reg, mod_high_reg, rsq_low_reg, rsq_high_reg;
    logic [127:0] out_reg, prod;
    mm128_pkg::mm128_cmd_t cmd;
    mm128_pkg::mm128_sts_t sts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_low_reg  <= 64'd1;
            mod_high_reg <= 64'd0;
            rsq_low_reg  <= 64'd0;
            rsq_high_reg <= 64'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mm128_pkg::REG_MOD_LOW:  mod_low_reg  <= cfg_data;
                mm128_pkg::REG_MOD_HIGH: mod_high_reg <= cfg_data;
                mm128_pkg::REG_RSQ_LOW:  rsq_low_reg  <= cfg_data;
                mm128_pkg::REG_RSQ_HIGH: rsq_high_reg <= cfg_data;
                default:                 mod_low_reg  <= mod_low_reg;
            endcase
        end
    end

    mm128_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_ready    (req.ready),
        .operation   (req.operation),
        .chain_start (req.chain_start),
        .out_valid   (res.valid),
        .out_ready   (res.ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    mm128_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_a_low  (req.a_low),
        .in_a_high (req.a_high),
        .in_b_low  (req.b_low),
        .in_b_high (req.b_high),
        .mod_low   (mod_low_reg),
        .mod_high  (mod_high_reg),
        .rsq_low   (rsq_low_reg),
        .rsq_high  (rsq_high_reg),
        .result    (prod)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg <= prod;
        end
        else if (cmd.out_run)
        begin
            out_reg <= {req.a_high, req.a_low};
        end
        else if (cmd.out_zero)
        begin
            out_reg <= 128'd0;
        end
    end

    assign res.result_low  = out_reg[63:0];
    assign res.result_high = out_reg[127:64];
endmodule

/* tb/sv/tb_mm128_pkg.sv */
`timescale 1ns / 100ps
// Testbench package: Montgomery product prediction and result scoreboard.
package tb_mm128_pkg;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] a_low;
        logic [63:0] a_high;
        logic [63:0] b_low;
        logic [63:0] b_high;
        logic        chain_start;
    } mm_req_t;

    class mm128_scoreboard;
        logic [127:0] modulus;
        logic [127:0] rsq;
        logic [127:0] running;
        logic [127:0] pending[$];
        int mismatches;

        function new();
            modulus = 128'd1;
            rsq = '0;
            running = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                mm128_pkg::REG_MOD_LOW:  modulus[63:0] = data;
                mm128_pkg::REG_MOD_HIGH: modulus[127:64] = data;
                mm128_pkg::REG_RSQ_LOW:  rsq[63:0] = data;
                default:                 rsq[127:64] = data;
            endcase
        endfunction

        // two word rounds with k = -low word, then one conditional subtract
        function logic [127:0] mont_product(logic [127:0] x, logic [127:0] y);
            logic [255:0] prod;
            logic [63:0]  k;
            logic [191:0] acc;
            logic [128:0] sum;
            logic [129:0] diff;
            prod = {128'd0, x} * {128'd0, y};
            k = 64'd0 - prod[63:0];
            acc = {64'd0, prod[127:0]} + {64'd0, k} * {64'd0, modulus};
            // only the upper 128 bits of the 192-bit accumulation survive
            acc = {64'd0, acc[191:64]};
            k = 64'd0 - acc[63:0];
            acc = acc + {64'd0, k} * {64'd0, modulus};
            sum = {1'b0, prod[255:128]} + {1'b0, acc[191:64]};
            diff = {1'b0, sum} - {2'b0, modulus};
            mont_product = diff[129] ? sum[127:0] : diff[127:0];
        endfunction

        function void note_request(mm_req_t r);
            logic [127:0] a, b, x, y, res;
            a = {r.a_high, r.a_low};
            b = {r.b_high, r.b_low};
            res = '0;
            case (r.operation)
                mm128_pkg::OP_MONT:  res = mont_product(a, b);
                mm128_pkg::OP_ENTER: res = mont_product(a, rsq);
                mm128_pkg::OP_EXIT:  res = mont_product(a, 128'd1);
                mm128_pkg::OP_FULL:
                begin
                    x = mont_product(a, rsq);
                    y = mont_product(b, rsq);
                    res = mont_product(mont_product(x, y), 128'd1);
                end
                mm128_pkg::OP_ACC:
                begin
                    running = r.chain_start ? a : mont_product(running, a);
                    res = running;
                end
                default: res = '0;
            endcase
            pending.push_back(res);
        endfunction

        function void check_result(logic [63:0] lo, logic [63:0] hi);
            logic [127:0] want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h_%h", hi, lo);
                return;
            end
            want = pending.pop_front();
            if (want[63:0] !== lo || want[127:64] !== hi)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %h_%h got %h_%h",
                             want[127:64], want[63:0], hi, lo);
            end
        endfunction
    endclass
endpackage

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Top-level testbench for the 128-bit Montgomery multiplier.
module tb;

    localparam int WatchLimit = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [63:0] cfg_data = '0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int watch_cnt = 0;
    tb_mm128_pkg::mm128_scoreboard sb;

    mm128_req_if req ();
    mm128_res_if res ();

    montgomery_mul_128_core dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .res(res.source),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        req.valid = 1'b0;
        req.operation = '0;
        req.a_low = '0;
        req.a_high = '0;
        req.b_low = '0;
        req.b_high = '0;
        req.chain_start = 1'b0;
        res.ready = 1'b0;
        sb = new();
    end

    // receiver with random stalls, checks each accepted result
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res.valid && res.ready)
                sb.check_result(res.result_low, res.result_high);
            res.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (res.valid && res.ready) || !rst_n)
            watch_cnt <= 0;
        else
            watch_cnt <= watch_cnt + 1;
        if (watch_cnt >= WatchLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_cfg(logic [1:0] idx, logic [63:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        sb.write_reg(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // valid stays up after acceptance until the next request or an idle cycle
    task automatic send_req(tb_mm128_pkg::mm_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.operation <= r.operation;
        req.a_low <= r.a_low;
        req.a_high <= r.a_high;
        req.b_low <= r.b_low;
        req.b_high <= r.b_high;
        req.chain_start <= r.chain_start;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic [63:0] rand_word();
        case ($urandom_range(5))
            0: rand_word = '0;
            1: rand_word = '1;
            default: rand_word = {$urandom, $urandom};
        endcase
    endfunction

    // modulus low word one (assumed case) mostly, sometimes arbitrary
    task automatic set_modulus(logic [63:0] lo, logic [63:0] hi,
                               logic [63:0] rl, logic [63:0] rh);
        drain();
        write_cfg(mm128_pkg::REG_MOD_LOW, lo);
        write_cfg(mm128_pkg::REG_MOD_HIGH, hi);
        write_cfg(mm128_pkg::REG_RSQ_LOW, rl);
        write_cfg(mm128_pkg::REG_RSQ_HIGH, rh);
    endtask

    function automatic tb_mm128_pkg::mm_req_t rand_req();
        tb_mm128_pkg::mm_req_t r;
        r.operation = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5))
                                                : 3'($urandom_range(4));
        r.a_low = rand_word();
        r.a_high = rand_word();
        r.b_low = rand_word();
        r.b_high = rand_word();
        r.chain_start = ($urandom_range(3) == 0);
        rand_req = r;
    endfunction

    initial
    begin
        tb_mm128_pkg::mm_req_t r;
        logic [2:0] op;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: reset config, every operation, extremes, unused codes
        for (int i = 0; i < 8; i++)
        begin
            op = 3'(i);
            r = '{op, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1};
            send_req(r);
            r = '{op, 64'd0, 64'd0, 64'd0, 64'd0, 1'b0};
            send_req(r);
        end
        set_modulus(64'd1, 64'hC139713E2EDB2345, 64'h10646E78, 64'h1);
        r = '{mm128_pkg::OP_ACC, 64'd5, 64'd7, 64'd0, 64'd0, 1'b1};
        send_req(r);
        r = '{mm128_pkg::OP_ACC, 64'd9, 64'd3, 64'd0, 64'd0, 1'b0};
        send_req(r);
        r = '{mm128_pkg::OP_ACC, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'd0, 64'd0, 1'b0};
        send_req(r);
        r = '{mm128_pkg::OP_FULL, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
              64'd2, 64'd0, 1'b0};
        send_req(r);
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase
            case (ph)
                0: set_modulus(64'd1, 64'hFFFF_FFFF_FFFF_FFFF,
                               64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
                1: set_modulus(64'd1, 64'd0, 64'd0, 64'd0);
                5: set_modulus(rand_word(), rand_word(), rand_word(), rand_word());
                default: set_modulus(64'd1, {$urandom, $urandom} | 64'h8000_0000_0000_0000,
                                     rand_word(), rand_word());
            endcase
            for (int n = 0; n < 250; n++)
            begin
                send_req(rand_req());
                if (n == 100)
                begin
                    // hold off until the block has returned everything
                    req.valid <= 1'b0;
                    while (sb.pending.size() != 0)
                        @(posedge clk);
                end
            end
        end
        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule

/* sim.f */
hdl/mm128_pkg.sv
hdl/mm128_if.sv
hdl/mm128_datapath.sv
hdl/mm128_ctrl.sv
hdl/montgomery_mul_128_core.sv
tb/sv/tb_mm128_pkg.sv
tb/sv/tb.sv
